FILE: rtl/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared widths, register indexes, state codes and the result word type for
// the longest-increasing-subsequence prefix-max tree.
// ----------------------------------------------------------------------------
package lis_pkg;

   localparam int unsigned MAX_RANK_DEFAULT = 1024;
   localparam int unsigned RANK_W           = 11;
   localparam int unsigned LEN_W            = 11;
   localparam int unsigned POS_W            = RANK_W + 1;  // room for pos + lowbit
   localparam int unsigned CSR_IDX_W        = 1;
   localparam int unsigned CSR_DATA_W       = 11;

   localparam logic [LEN_W-1:0]     LEN_MAX          = '1;
   localparam logic [RANK_W-1:0]    RANK_COUNT_RESET = 11'd1024;

   localparam logic [CSR_IDX_W-1:0] CSR_RANK_COUNT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE_ORDER = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_QUERY,
      ST_UPDATE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic             valid;
      logic             rank_error;
      logic [LEN_W-1:0] lis_length;
   } result_type;

endpackage

FILE: rtl/lis_length_prefix_max_tree_top.sv
// ----------------------------------------------------------------------------
// lis_length_prefix_max_tree_top
// Longest strictly increasing subsequence length per streamed rank, kept in a
// Fenwick prefix-maximum table held in one synchronous memory.
// ----------------------------------------------------------------------------
// Operation: a query walk of popcount(rank-1) reads, then the raise steps, then
//   the response; both walks read 11 entries in all at rank_count 1024, and
//   rank 1 has no query walk; an out-of-range word skips both walks.
// A new word is accepted only once the last one has been answered; start_new adds a clearing pass.
// Reset clears control and loads rank_count = 1024, reverse_order = 0, then
//   runs a clearing pass over the table with req_ready low.
module lis_length_prefix_max_tree_top #(
   parameter int unsigned MAX_RANK = lis_pkg::MAX_RANK_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lis_pkg::RANK_W-1:0]        req_value_rank,
   input  logic                              req_start_new,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lis_pkg::LEN_W-1:0]         rsp_lis_length,
   output logic                              rsp_rank_error,
   input  logic                              csr_wr_en,
   input  logic [lis_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lis_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned AW = $clog2(MAX_RANK);

   logic [lis_pkg::RANK_W-1:0] rank_count_ff;
   logic                       reverse_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lis_pkg::LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic                       rsp_err_ff, rsp_err_in;
   logic                       slot_free;
   lis_pkg::result_type        result;

   logic                       mem_rd_en;
   logic [AW-1:0]              mem_rd_addr;
   logic [lis_pkg::LEN_W-1:0]  mem_rd_data;
   logic                       mem_wr_en;
   logic [AW-1:0]              mem_wr_addr;
   logic [lis_pkg::LEN_W-1:0]  mem_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_count_ff <= lis_pkg::RANK_COUNT_RESET;
         reverse_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            lis_pkg::CSR_RANK_COUNT:    rank_count_ff <= csr_wdata;
            lis_pkg::CSR_REVERSE_ORDER: reverse_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // output word register parts the sequencer from the consumer
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_len_in   = rsp_len_ff;
      rsp_err_in   = rsp_err_ff;
      if (result.valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_len_in   = result.lis_length;
         rsp_err_in   = result.rank_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_len_ff <= rsp_len_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lis_length = rsp_len_ff;
   assign rsp_rank_error = rsp_err_ff;

   lis_walk_ctrl #(
      .MAX_RANK (MAX_RANK)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value_rank (req_value_rank),
      .req_start_new  (req_start_new),
      .rank_count     (rank_count_ff),
      .reverse_order  (reverse_ff),
      .slot_free      (slot_free),
      .result         (result),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data)
   );

   lis_tree_mem #(
      .DEPTH (MAX_RANK)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

endmodule

FILE: rtl/lis_tree_mem.sv
// ----------------------------------------------------------------------------
// lis_tree_mem
// Best-length table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lis_tree_mem #(
   parameter int unsigned DEPTH = lis_pkg::MAX_RANK_DEFAULT
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [lis_pkg::LEN_W-1:0]    rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [lis_pkg::LEN_W-1:0]    wr_data
);

   logic [lis_pkg::LEN_W-1:0] mem [DEPTH];
   logic [lis_pkg::LEN_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lis_walk_ctrl.sv
// ----------------------------------------------------------------------------
// lis_walk_ctrl
// Sequencer: clearing sweep, Fenwick prefix-max query walk, then the
// read-modify-write raise walk; walk reads are issued back to back, each raise write-back overlapping the next read.
// ----------------------------------------------------------------------------
module lis_walk_ctrl #(
   parameter int unsigned MAX_RANK = lis_pkg::MAX_RANK_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lis_pkg::RANK_W-1:0]      req_value_rank,
   input  logic                            req_start_new,
   input  logic [lis_pkg::RANK_W-1:0]      rank_count,
   input  logic                            reverse_order,
   input  logic                            slot_free,
   output lis_pkg::result_type             result,
   output logic                            mem_rd_en,
   output logic [$clog2(MAX_RANK)-1:0]     mem_rd_addr,
   input  logic [lis_pkg::LEN_W-1:0]       mem_rd_data,
   output logic                            mem_wr_en,
   output logic [$clog2(MAX_RANK)-1:0]     mem_wr_addr,
   output logic [lis_pkg::LEN_W-1:0]       mem_wr_data
);

   localparam int unsigned AW   = $clog2(MAX_RANK);
   localparam int unsigned RW   = lis_pkg::RANK_W;
   localparam int unsigned PW   = lis_pkg::POS_W;
   localparam int unsigned LW   = lis_pkg::LEN_W;
   localparam int unsigned CAP  = (MAX_RANK > 2047) ? 2047 : MAX_RANK;
   localparam logic [RW-1:0] CAP_RANK  = RW'(CAP);
   localparam logic [AW-1:0] CLR_LAST  = AW'(MAX_RANK - 1);

   lis_pkg::state_type state_ff, state_in;
   logic [RW-1:0] rank_ff, rank_in;
   logic [RW-1:0] n_ff, n_in;
   logic          err_ff, err_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [LW-1:0] best_ff, best_in;
   logic [LW-1:0] len_ff, len_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          from_item_ff, from_item_in;

   logic [RW-1:0] n_eff;
   logic          rank_bad;
   logic [RW-1:0] rank_eff;
   logic [LW-1:0] len_next;
   logic [AW-1:0] pos_addr;

   function automatic logic [PW-1:0] low_bit(input logic [PW-1:0] x);
      return x & (~x + PW'(1));
   endfunction

   // table index p lives at address p-1
   function automatic logic [AW-1:0] to_addr(input logic [PW-1:0] p);
      logic [AW+PW-1:0] ext;
      ext = {{AW{1'b0}}, p - PW'(1)};
      return ext[AW-1:0];
   endfunction

   always_comb begin
      n_eff    = (rank_count > CAP_RANK) ? CAP_RANK : rank_count;
      rank_bad = (req_value_rank == '0) || (req_value_rank > n_eff);
      rank_eff = reverse_order ? (n_eff - req_value_rank + RW'(1)) : req_value_rank;
      len_next = (best_ff == lis_pkg::LEN_MAX) ? lis_pkg::LEN_MAX : best_ff + LW'(1);
      pos_addr = to_addr(pos_ff);
   end

   always_comb begin
      state_in     = state_ff;
      rank_in      = rank_ff;
      n_in         = n_ff;
      err_in       = err_ff;
      pos_in       = pos_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      best_in      = best_ff;
      len_in       = len_ff;
      clr_in       = clr_ff;
      from_item_in = from_item_ff;

      req_ready    = 1'b0;
      result       = '{valid: 1'b0, rank_error: err_ff, lis_length: len_ff};
      mem_rd_en    = 1'b0;
      mem_rd_addr  = pos_addr;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = pend_addr_ff;
      mem_wr_data  = len_ff;

      case (state_ff)
         lis_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rank_in      = rank_eff;
               n_in         = n_eff;
               err_in       = rank_bad;
               pos_in       = {1'b0, rank_eff} - PW'(1);
               pend_in      = 1'b0;
               best_in      = '0;
               len_in       = '0;
               clr_in       = '0;
               from_item_in = 1'b1;
               if (req_start_new) begin
                  state_in = lis_pkg::ST_CLEAR;
               end else if (rank_bad) begin
                  state_in = lis_pkg::ST_RESP;
               end else begin
                  state_in = lis_pkg::ST_QUERY;
               end
            end
         end

         lis_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            if (clr_ff == CLR_LAST) begin
               if (!from_item_ff) begin
                  state_in = lis_pkg::ST_IDLE;
               end else if (err_ff) begin
                  state_in = lis_pkg::ST_RESP;
               end else begin
                  state_in = lis_pkg::ST_QUERY;
               end
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end

         lis_pkg::ST_QUERY: begin
            // reads are issued back to back, data folded in the following cycle
            if (pend_ff && (mem_rd_data > best_ff)) begin
               best_in = mem_rd_data;
            end
            if (pos_ff != '0) begin
               mem_rd_en = 1'b1;
               pos_in    = pos_ff - low_bit(pos_ff);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  len_in   = len_next;
                  pos_in   = {1'b0, rank_ff};
                  state_in = lis_pkg::ST_UPDATE;
               end
            end
         end

         lis_pkg::ST_UPDATE: begin
            // write-back of the previous entry never hits the address read now
            if (pend_ff && (mem_rd_data < len_ff)) begin
               mem_wr_en = 1'b1;
            end
            if (pos_ff <= {1'b0, n_ff}) begin
               mem_rd_en    = 1'b1;
               pend_addr_in = pos_addr;
               pos_in       = pos_ff + low_bit(pos_ff);
               pend_in      = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = lis_pkg::ST_RESP;
               end
            end
         end

         lis_pkg::ST_RESP: begin
            result.valid = 1'b1;
            if (slot_free) begin
               state_in = lis_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lis_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lis_pkg::ST_CLEAR;
         clr_ff       <= '0;
         from_item_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         from_item_ff <= from_item_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rank_ff      <= rank_in;
      n_ff         <= n_in;
      err_ff       <= err_in;
      pos_ff       <= pos_in;
      pend_addr_ff <= pend_addr_in;
      best_ff      <= best_in;
      len_ff       <= len_in;
   end

endmodule
